@@ sv/sorted_alarm_timer_queue_defines.svh @@
// Assertion macros shared by the timer queue RTL.
`ifndef SORTED_ALARM_TIMER_QUEUE_DEFINES_SVH
`define SORTED_ALARM_TIMER_QUEUE_DEFINES_SVH

// Checks a property on every clock edge outside reset.
`define SATQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks a property that is also meaningful while reset is held.
`define SATQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ sv/satq_pkg.sv @@
package satq_pkg;

  localparam int unsigned SLOTS_DEFAULT = 64;

  typedef enum logic [1:0] {
    REQ_SET     = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_TICK    = 2'd2,
    REQ_SERVICE = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_SCHEDULED = 3'd0,
    ST_RELEASED  = 3'd1,
    ST_FIRED     = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_ALREADY   = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SET_SCAN,
    S_INS_RD,
    S_INS_SHIFT,
    S_INS_WRITE,
    S_REL_SCAN,
    S_SVC_HEAD,
    S_SVC_POP,
    S_REM_RD,
    S_REM_COPY,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] delay_ticks;
    logic [5:0]  alarm_handle;
    logic [31:0] handler_address;
    logic [31:0] user_argument;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  alarm_id;
    logic [15:0] fired_target;
    logic [15:0] release_elapsed;
    logic [31:0] fired_handler;
    logic [31:0] fired_argument;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [15:0] delay;
    logic [15:0] target;
    logic [5:0]  id;
    logic [31:0] handler;
    logic [31:0] argument;
  } entry_t;

endpackage

@@ sv/sorted_alarm_timer_queue.sv @@
// Tick gives no result and leaves busy low; set, release and service raise busy while they
// scan and move entries (one memory access per cycle through the scan and the move).
// Throughput: one transaction at a time; the next is taken in the cycle busy drops.
// A service emits one fired result per cycle, then compacts the queue.
// Results are registered and shown for one cycle; the receiver cannot stall.
// Reset clears counter, comparator, flags, count and id bitmap; the table is not cleared.
`include "sorted_alarm_timer_queue_defines.svh"

module sorted_alarm_timer_queue #(
  parameter int unsigned ALARM_SLOTS = satq_pkg::SLOTS_DEFAULT
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  satq_pkg::req_t  req_i,
  output logic            res_valid_o,
  output satq_pkg::res_t  res_o
);

  localparam int unsigned AW = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
  localparam int unsigned CW = $clog2(ALARM_SLOTS + 1);

  satq_pkg::state_e state_q, state_d;
  logic [15:0]      tick_q, tick_d;
  logic [15:0]      cmp_q, cmp_d;
  logic             cmp_en_q, cmp_en_d;
  logic             pend_q, pend_d;
  logic [CW-1:0]    count_q, count_d;
  logic [ALARM_SLOTS-1:0] in_use_q, in_use_d;
  logic [15:0]      head_q, head_d;
  satq_pkg::req_t   op_q, op_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    pos_q, pos_d;
  logic [CW-1:0]    gap_q, gap_d;
  logic [5:0]       newid_q, newid_d;
  logic [15:0]      t0_q, t0_d;
  satq_pkg::entry_t hold_q, hold_d;
  satq_pkg::res_t   res_q, res_d;
  logic             res_vld_q, res_vld_d;

  satq_pkg::entry_t mem [ALARM_SLOTS];
  satq_pkg::entry_t rd_q;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [AW-1:0]    mem_raddr;
  satq_pkg::entry_t mem_wdata;

  logic             accept;
  logic             free_found;
  logic [5:0]       free_id;

  assign busy        = (state_q != satq_pkg::S_IDLE);
  assign accept      = start && !busy;
  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  // Lowest free id in the bitmap.
  always_comb begin
    free_found = 1'b0;
    free_id    = '0;
    for (int k = ALARM_SLOTS - 1; k >= 0; k--) begin
      if (!in_use_q[k]) begin
        free_found = 1'b1;
        free_id    = 6'(k);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= satq_pkg::S_IDLE;
      tick_q    <= '0;
      cmp_q     <= '0;
      cmp_en_q  <= 1'b0;
      pend_q    <= 1'b0;
      count_q   <= '0;
      in_use_q  <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      tick_q    <= tick_d;
      cmp_q     <= cmp_d;
      cmp_en_q  <= cmp_en_d;
      pend_q    <= pend_d;
      count_q   <= count_d;
      in_use_q  <= in_use_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q  <= head_d;
    op_q    <= op_d;
    idx_q   <= idx_d;
    pos_q   <= pos_d;
    gap_q   <= gap_d;
    newid_q <= newid_d;
    t0_q    <= t0_d;
    hold_q  <= hold_d;
    res_q   <= res_d;
  end

  always_comb begin
    logic [16:0]   tgt17;
    logic [16:0]   adj17;
    logic [CW:0]   idx_n;
    logic [CW:0]   src;
    logic [CW-1:0] cnt_new;
    logic          last_pop;

    state_d   = state_q;
    tick_d    = tick_q;
    cmp_d     = cmp_q;
    cmp_en_d  = cmp_en_q;
    pend_d    = pend_q;
    count_d   = count_q;
    in_use_d  = in_use_q;
    op_d      = op_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    gap_d     = gap_q;
    newid_d   = newid_q;
    t0_d      = t0_q;
    hold_d    = hold_q;
    res_d     = '0;
    res_vld_d = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = rd_q;
    mem_raddr = '0;

    tgt17    = {1'b0, tick_q} + {1'b0, op_q.delay_ticks};
    adj17    = (rd_q.target < tick_q) ? {1'b1, rd_q.target} : {1'b0, rd_q.target};
    idx_n    = {1'b0, idx_q} + 1'b1;
    src      = {1'b0, pos_q} + {1'b0, gap_q};
    cnt_new  = count_q - gap_q;
    last_pop = (idx_n == {1'b0, count_q}) || (rd_q.target != t0_q);

    unique case (state_q)
      satq_pkg::S_IDLE: begin
        if (accept) begin
          op_d  = req_i;
          idx_d = '0;
          unique case (req_i.req_type)
            satq_pkg::REQ_TICK: begin
              tick_d = tick_q + 16'd1;
              if (cmp_en_q && (tick_d == cmp_q)) begin
                pend_d = 1'b1;
              end
            end
            satq_pkg::REQ_SET: begin
              if ((count_q >= CW'(ALARM_SLOTS)) || !free_found) begin
                res_vld_d    = 1'b1;
                res_d.status = satq_pkg::ST_FULL;
                res_d.last   = 1'b1;
              end else begin
                newid_d = free_id;
                if (count_q == '0) begin
                  pos_d   = '0;
                  state_d = satq_pkg::S_INS_WRITE;
                end else begin
                  state_d = satq_pkg::S_SET_SCAN;
                end
              end
            end
            satq_pkg::REQ_RELEASE: begin
              if (count_q == '0) begin
                res_vld_d      = 1'b1;
                res_d.status   = satq_pkg::ST_NOT_FOUND;
                res_d.alarm_id = req_i.alarm_handle;
                res_d.last     = 1'b1;
              end else begin
                state_d = satq_pkg::S_REL_SCAN;
              end
            end
            default: begin
              if (count_q == '0) begin
                cmp_en_d = 1'b0;
                pend_d   = 1'b0;
              end else begin
                state_d = satq_pkg::S_SVC_HEAD;
              end
            end
          endcase
        end
      end

      // rd_q holds the entry at idx_q; the next one is fetched meanwhile.
      satq_pkg::S_SET_SCAN: begin
        mem_raddr = idx_n[AW-1:0];
        if (tgt17 < adj17) begin
          pos_d   = idx_q;
          state_d = satq_pkg::S_INS_RD;
        end else if (idx_n == {1'b0, count_q}) begin
          pos_d   = count_q;
          state_d = satq_pkg::S_INS_RD;
        end else begin
          idx_d = idx_n[CW-1:0];
        end
      end

      satq_pkg::S_INS_RD: begin
        if (pos_q == count_q) begin
          state_d = satq_pkg::S_INS_WRITE;
        end else begin
          mem_raddr = AW'(count_q - 1'b1);
          idx_d     = count_q;
          state_d   = satq_pkg::S_INS_SHIFT;
        end
      end

      // Moves entries up by one, from the tail down to the insert position.
      satq_pkg::S_INS_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q[AW-1:0];
        mem_wdata = rd_q;
        if ((idx_q - 1'b1) == pos_q) begin
          state_d = satq_pkg::S_INS_WRITE;
        end else begin
          mem_raddr = AW'(idx_q - 2'd2);
          idx_d     = idx_q - 1'b1;
        end
      end

      satq_pkg::S_INS_WRITE: begin
        mem_we             = 1'b1;
        mem_waddr          = pos_q[AW-1:0];
        mem_wdata.delay    = op_q.delay_ticks;
        mem_wdata.target   = tgt17[15:0];
        mem_wdata.id       = newid_q;
        mem_wdata.handler  = op_q.handler_address;
        mem_wdata.argument = op_q.user_argument;
        count_d            = count_q + 1'b1;
        in_use_d[newid_q[AW-1:0]] = 1'b1;
        cmp_d              = (pos_q == '0) ? tgt17[15:0] : head_q;
        cmp_en_d           = 1'b1;
        res_vld_d          = 1'b1;
        res_d.status       = satq_pkg::ST_SCHEDULED;
        res_d.alarm_id     = newid_q;
        res_d.last         = 1'b1;
        state_d            = satq_pkg::S_IDLE;
      end

      satq_pkg::S_REL_SCAN: begin
        mem_raddr = idx_n[AW-1:0];
        if (rd_q.id == op_q.alarm_handle) begin
          if ((rd_q.target == cmp_q) && pend_q) begin
            res_vld_d      = 1'b1;
            res_d.status   = satq_pkg::ST_ALREADY;
            res_d.alarm_id = op_q.alarm_handle;
            res_d.last     = 1'b1;
            state_d        = satq_pkg::S_IDLE;
          end else begin
            t0_d    = rd_q.delay;
            pos_d   = idx_q;
            gap_d   = CW'(1);
            state_d = satq_pkg::S_REM_RD;
          end
        end else if (idx_n == {1'b0, count_q}) begin
          res_vld_d      = 1'b1;
          res_d.status   = satq_pkg::ST_NOT_FOUND;
          res_d.alarm_id = op_q.alarm_handle;
          res_d.last     = 1'b1;
          state_d        = satq_pkg::S_IDLE;
        end else begin
          idx_d = idx_n[CW-1:0];
        end
      end

      satq_pkg::S_SVC_HEAD: begin
        hold_d    = rd_q;
        t0_d      = rd_q.target;
        mem_raddr = AW'(1);
        state_d   = satq_pkg::S_SVC_POP;
      end

      // hold_q is the alarm being fired; rd_q is the one behind it.
      satq_pkg::S_SVC_POP: begin
        res_vld_d            = 1'b1;
        res_d.status         = satq_pkg::ST_FIRED;
        res_d.alarm_id       = hold_q.id;
        res_d.fired_target   = t0_q;
        res_d.fired_handler  = hold_q.handler;
        res_d.fired_argument = hold_q.argument;
        res_d.last           = last_pop;
        in_use_d[hold_q.id[AW-1:0]] = 1'b0;
        if (last_pop) begin
          pos_d   = '0;
          gap_d   = idx_n[CW-1:0];
          state_d = satq_pkg::S_REM_RD;
        end else begin
          hold_d    = rd_q;
          idx_d     = idx_n[CW-1:0];
          mem_raddr = AW'(idx_n + 1'b1);
        end
      end

      satq_pkg::S_REM_RD: begin
        if (src >= {1'b0, count_q}) begin
          state_d = satq_pkg::S_FINISH;
        end else begin
          mem_raddr = src[AW-1:0];
          state_d   = satq_pkg::S_REM_COPY;
        end
      end

      // Closes the gap: entry pos+gap moves to pos, one per cycle.
      satq_pkg::S_REM_COPY: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q[AW-1:0];
        mem_wdata = rd_q;
        if ((src + 1'b1) >= {1'b0, count_q}) begin
          state_d = satq_pkg::S_FINISH;
        end else begin
          mem_raddr = AW'(src + 1'b1);
          pos_d     = pos_q + 1'b1;
        end
      end

      satq_pkg::S_FINISH: begin
        count_d = cnt_new;
        state_d = satq_pkg::S_IDLE;
        if (op_q.req_type == satq_pkg::REQ_RELEASE) begin
          in_use_d[op_q.alarm_handle[AW-1:0]] = 1'b0;
          if (cnt_new == '0) begin
            cmp_en_d = 1'b0;
          end else if (idx_q == '0) begin
            cmp_d    = head_q;
            cmp_en_d = 1'b1;
          end
          res_vld_d             = 1'b1;
          res_d.status          = satq_pkg::ST_RELEASED;
          res_d.alarm_id        = op_q.alarm_handle;
          res_d.release_elapsed = tick_q - t0_q;
          res_d.last            = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (cnt_new == '0) begin
            cmp_en_d = 1'b0;
          end else begin
            cmp_d    = head_q;
            cmp_en_d = 1'b1;
          end
        end
      end

      default: begin
        state_d = satq_pkg::S_IDLE;
      end
    endcase

    // Mirror of the head target, kept in step with every write to slot zero.
    head_d = head_q;
    if (mem_we && (mem_waddr == '0)) begin
      head_d = mem_wdata.target;
    end
  end

  `SATQ_ASSERT(a_count_range, count_q <= CW'(ALARM_SLOTS), "entry count exceeds slots")
  `SATQ_ASSERT(a_bitmap_matches, !busy |-> ($countones(in_use_q) == count_q), "id bitmap and count disagree")
  `SATQ_ASSERT(a_enable_nonempty, (!busy && cmp_en_q) |-> (count_q != '0), "compare enabled on empty queue")
  `SATQ_ASSERT(a_fire_burst, (res_vld_q && (res_q.status == satq_pkg::ST_FIRED) && !res_q.last) |=> res_vld_q, "fired burst broken")
  `SATQ_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !res_vld_q, "result strobe during reset")

endmodule

@@ test/testbench.sv @@
module testbench;

  localparam int unsigned NSLOT = satq_pkg::SLOTS_DEFAULT;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  satq_pkg::req_t req_i = '0;
  logic res_valid_o;
  satq_pkg::res_t res_o;

  sorted_alarm_timer_queue #(.ALARM_SLOTS(NSLOT)) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .req_i(req_i),
    .res_valid_o(res_valid_o),
    .res_o(res_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Mirror of the alarm queue state.
  logic [15:0] now_q;
  logic [15:0] cmp_q;
  logic        cmp_en_q;
  logic        cmp_pend_q;
  int          depth_q;
  logic [63:0] ids_busy_q;
  satq_pkg::entry_t queue_q [NSLOT];

  satq_pkg::res_t pending_results [$];
  int   mismatches = 0;
  bit   failed = 1'b0;

  function automatic satq_pkg::res_t mk_res(satq_pkg::status_e st, logic [5:0] id,
                                            logic [15:0] ft, logic [15:0] el,
                                            logic [31:0] fh, logic [31:0] fa);
    satq_pkg::res_t r;
    r = '0;
    r.status = st;
    r.alarm_id = id;
    r.fired_target = ft;
    r.release_elapsed = el;
    r.fired_handler = fh;
    r.fired_argument = fa;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic drop_entry(int pos);
    for (int k = pos; k + 1 < depth_q; k++) queue_q[k] = queue_q[k + 1];
    depth_q--;
  endtask

  task automatic predict_queue(satq_pkg::req_t rq);
    int id;
    int pos;
    logic [16:0] tgt;
    logic [16:0] t;
    logic [15:0] t0;
    satq_pkg::entry_t e;
    satq_pkg::res_t r;
    case (satq_pkg::req_e'(rq.req_type))
      satq_pkg::REQ_SET: begin
        id = -1;
        if (depth_q < NSLOT)
          for (int k = 0; k < NSLOT; k++)
            if (!ids_busy_q[k] && id < 0) id = k;
        if (id < 0) begin
          pending_results.push_back(mk_res(satq_pkg::ST_FULL, 0, 0, 0, 0, 0));
        end else begin
          ids_busy_q[id] = 1'b1;
          tgt = {1'b0, now_q} + {1'b0, rq.delay_ticks};
          pos = depth_q;
          for (int k = 0; k < depth_q; k++) begin
            t = {1'b0, queue_q[k].target};
            if (queue_q[k].target < now_q) t[16] = 1'b1;
            if (tgt < t && pos == depth_q) pos = k;
          end
          for (int k = depth_q; k > pos; k--) queue_q[k] = queue_q[k - 1];
          e.delay = rq.delay_ticks;
          e.target = tgt[15:0];
          e.id = id[5:0];
          e.handler = rq.handler_address;
          e.argument = rq.user_argument;
          queue_q[pos] = e;
          depth_q++;
          cmp_q = queue_q[0].target;
          cmp_en_q = 1'b1;
          pending_results.push_back(mk_res(satq_pkg::ST_SCHEDULED, id[5:0], 0, 0, 0, 0));
        end
      end
      satq_pkg::REQ_RELEASE: begin
        pos = -1;
        for (int k = 0; k < depth_q; k++)
          if (queue_q[k].id == rq.alarm_handle && pos < 0) pos = k;
        if (pos < 0) begin
          pending_results.push_back(mk_res(satq_pkg::ST_NOT_FOUND, rq.alarm_handle,
                                           0, 0, 0, 0));
        end else if (queue_q[pos].target == cmp_q && cmp_pend_q) begin
          pending_results.push_back(mk_res(satq_pkg::ST_ALREADY, rq.alarm_handle,
                                           0, 0, 0, 0));
        end else begin
          e = queue_q[pos];
          drop_entry(pos);
          ids_busy_q[rq.alarm_handle] = 1'b0;
          if (depth_q == 0) cmp_en_q = 1'b0;
          else if (pos == 0) begin
            cmp_q = queue_q[0].target;
            cmp_en_q = 1'b1;
          end
          pending_results.push_back(mk_res(satq_pkg::ST_RELEASED, rq.alarm_handle, 0,
                                           now_q - e.delay, 0, 0));
        end
      end
      satq_pkg::REQ_TICK: begin
        now_q = now_q + 16'd1;
        if (cmp_en_q && now_q == cmp_q) cmp_pend_q = 1'b1;
      end
      default: begin
        if (depth_q > 0) begin
          t0 = queue_q[0].target;
          do begin
            e = queue_q[0];
            r = mk_res(satq_pkg::ST_FIRED, e.id, t0, 0, e.handler, e.argument);
            r.last = 1'b0;
            pending_results.push_back(r);
            ids_busy_q[e.id] = 1'b0;
            drop_entry(0);
          end while (depth_q > 0 && queue_q[0].target == t0);
          pending_results[pending_results.size() - 1].last = 1'b1;
        end
        if (depth_q > 0) begin
          cmp_q = queue_q[0].target;
          cmp_en_q = 1'b1;
        end else cmp_en_q = 1'b0;
        cmp_pend_q = 1'b0;
      end
    endcase
  endtask

  task automatic flag_mismatch(satq_pkg::res_t want, satq_pkg::res_t got);
    failed = 1'b1;
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch: expected %p, actual %p", want, got);
  endtask

  // Results are checked as they appear; a pinned row is checked here too.
  satq_pkg::res_t pinned_q [$];
  bit   pinned_use [$];

  always @(posedge clk_i) begin
    satq_pkg::res_t want;
    if (rst_ni && res_valid_o) begin
      if (pending_results.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", res_o);
      end else begin
        want = pending_results.pop_front();
        if (res_o.status !== want.status || res_o.alarm_id !== want.alarm_id ||
            res_o.fired_target !== want.fired_target ||
            res_o.release_elapsed !== want.release_elapsed ||
            res_o.fired_handler !== want.fired_handler ||
            res_o.fired_argument !== want.fired_argument ||
            res_o.last !== want.last)
          flag_mismatch(want, res_o);
        if (pinned_use.size() > 0) begin
          if (pinned_use.pop_front() && pinned_q[0] !== res_o) flag_mismatch(pinned_q[0], res_o);
          void'(pinned_q.pop_front());
        end
      end
    end
  end

  bit calm = 1'b0;

  // Start stays high between back-to-back transactions and drops only while idling.
  task automatic send_item(satq_pkg::req_t rq);
    while (!calm && $urandom_range(99) < 38) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= rq;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_queue(rq);
  endtask

  function automatic satq_pkg::req_t mk_req(satq_pkg::req_e op, logic [15:0] dly,
                                            logic [5:0] h, logic [31:0] fh,
                                            logic [31:0] fa);
    satq_pkg::req_t rq;
    rq.req_type = op;
    rq.delay_ticks = dly;
    rq.alarm_handle = h;
    rq.handler_address = fh;
    rq.user_argument = fa;
    return rq;
  endfunction

  typedef struct {
    satq_pkg::req_t rq;
    bit   pin;
    satq_pkg::res_t want;
  } row_t;

  row_t plan [$];

  task automatic add_row(satq_pkg::req_t rq, bit pin, satq_pkg::res_t want);
    row_t rw;
    rw.rq = rq;
    rw.pin = pin;
    rw.want = want;
    plan.push_back(rw);
  endtask

  task automatic drain_queue();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (pending_results.size() > 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (150) @(posedge clk_i);
  endtask

  task automatic random_item();
    int p;
    logic [5:0] h;
    p = $urandom_range(99);
    if (depth_q > 0 && $urandom_range(3) != 0) h = queue_q[$urandom_range(depth_q - 1)].id;
    else h = 6'($urandom_range(63));
    if (p < 35)
      send_item(mk_req(satq_pkg::REQ_SET, ($urandom_range(3) == 0) ? 16'($urandom) :
                       16'($urandom_range(6)), 6'($urandom), $urandom, $urandom));
    else if (p < 50)
      send_item(mk_req(satq_pkg::REQ_RELEASE, 16'($urandom), h, $urandom, $urandom));
    else if (p < 85)
      send_item(mk_req(satq_pkg::REQ_TICK, 16'($urandom), 6'($urandom), $urandom, $urandom));
    else
      send_item(mk_req(satq_pkg::REQ_SERVICE, 16'($urandom), 6'($urandom), $urandom,
                       $urandom));
  endtask

  initial begin
    now_q = '0;
    cmp_q = '0;
    cmp_en_q = 1'b0;
    cmp_pend_q = 1'b0;
    depth_q = 0;
    ids_busy_q = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows: empty-table cases, extremes, equal targets, wrap order.
    add_row(mk_req(satq_pkg::REQ_RELEASE, 0, 6'd63, 0, 0), 1,
            mk_res(satq_pkg::ST_NOT_FOUND, 63, 0, 0, 0, 0));
    add_row(mk_req(satq_pkg::REQ_SERVICE, 0, 0, 0, 0), 0, '0);
    add_row(mk_req(satq_pkg::REQ_SET, 16'hffff, 0, 32'hffffffff, 32'hffffffff), 1,
            mk_res(satq_pkg::ST_SCHEDULED, 0, 0, 0, 0, 0));
    add_row(mk_req(satq_pkg::REQ_SET, 16'd2, 6'd63, 32'h0, 32'h0), 1,
            mk_res(satq_pkg::ST_SCHEDULED, 1, 0, 0, 0, 0));
    add_row(mk_req(satq_pkg::REQ_SET, 16'd2, 0, 32'h12345678, 32'h9abcdef0), 0, '0);
    add_row(mk_req(satq_pkg::REQ_SET, 16'd0, 0, 32'h1, 32'h2), 0, '0);
    add_row(mk_req(satq_pkg::REQ_TICK, 0, 0, 0, 0), 0, '0);
    add_row(mk_req(satq_pkg::REQ_TICK, 0, 0, 0, 0), 0, '0);
    add_row(mk_req(satq_pkg::REQ_RELEASE, 0, 6'd1, 0, 0), 1,
            mk_res(satq_pkg::ST_RELEASED, 1, 0, 0, 0, 0));
    add_row(mk_req(satq_pkg::REQ_SERVICE, 0, 0, 0, 0), 0, '0);
    add_row(mk_req(satq_pkg::REQ_SERVICE, 0, 0, 0, 0), 0, '0);
    add_row(mk_req(satq_pkg::REQ_RELEASE, 0, 6'd0, 0, 0), 0, '0);
    add_row(mk_req(satq_pkg::REQ_RELEASE, 0, 6'd0, 0, 0), 1,
            mk_res(satq_pkg::ST_NOT_FOUND, 0, 0, 0, 0, 0));
    add_row(mk_req(satq_pkg::REQ_SET, 16'd65534, 0, 32'hdead, 32'hbeef), 0, '0);
    add_row(mk_req(satq_pkg::REQ_SET, 16'd1, 0, 32'h5, 32'h6), 0, '0);
    add_row(mk_req(satq_pkg::REQ_SERVICE, 0, 0, 0, 0), 0, '0);
    add_row(mk_req(satq_pkg::REQ_SERVICE, 0, 0, 0, 0), 0, '0);
    foreach (plan[i]) begin
      if (plan[i].pin) begin
        pinned_q.push_back(plan[i].want);
      end
      send_item(plan[i].rq);
      // Only single-result rows are pinned; other rows fill the slot with no check.
      if (!plan[i].pin) begin
        for (int k = pinned_use.size(); k < pending_results.size(); k++) begin
          pinned_use.push_back(1'b0);
          pinned_q.push_back('0);
        end
      end else pinned_use.push_back(1'b1);
      drain_queue();
    end
    pinned_use.delete();
    pinned_q.delete();

    // Fill the table to full, then overflow twice.
    calm = 1'b1;
    for (int i = 0; i < NSLOT + 2; i++)
      send_item(mk_req(satq_pkg::REQ_SET, 16'($urandom_range(3)), 6'($urandom), $urandom,
                       $urandom));
    calm = 1'b0;
    send_item(mk_req(satq_pkg::REQ_SERVICE, 0, 0, 0, 0));
    drain_queue();

    for (int i = 0; i < 250; i++) begin
      calm = (i >= 100 && i < 160);
      random_item();
      if (i == 200) drain_queue();
    end
    calm = 1'b0;
    drain_queue();

    if (!failed && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("status: fail");
    $finish;
  end

endmodule
